@@ design/assert_macros.svh @@
// assertion macros shared by the flux unit rtl
// no dependencies; each macro expands to one labelled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while the active-low reset is applied
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/ecf_pkg.sv @@
// types and constants of the euler cell flux unit
// no dependencies; used by euler_cell_flux_unit
`timescale 1ns / 1ps

package ecf_pkg;

    // enthalpy factor register, unsigned q8.16
    localparam int          ENTH_W     = 24;
    localparam logic [23:0] ENTH_RESET = 24'd229376;  // 3.5, gamma of 1.4

    // register stages from accept to result strobe
    localparam int PIPE_DEPTH = 7;

    // one cell, q16.16
    typedef struct packed {
        logic        [31:0] density;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] velocity_z;
        logic        [31:0] pressure;
    } t_cell_in;

    // fluxes of one cell, signed q48.16
    typedef struct packed {
        logic signed [63:0] mass_flux_x;
        logic signed [63:0] mass_flux_y;
        logic signed [63:0] mass_flux_z;
        logic signed [63:0] momentum_xx;
        logic signed [63:0] momentum_xy;
        logic signed [63:0] momentum_xz;
        logic signed [63:0] momentum_yy;
        logic signed [63:0] momentum_yz;
        logic signed [63:0] momentum_zz;
        logic signed [63:0] energy_flux_x;
        logic signed [63:0] energy_flux_y;
        logic signed [63:0] energy_flux_z;
    } t_cell_flux;

endpackage

@@ design/euler_cell_flux_unit.sv @@
// inviscid euler flux of one grid cell, seven-stage multiply pipeline
// depends on ecf_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// usage
//   input channel: a cell word on i_cell is taken at a rising edge where start
//   is high and busy is low. busy is high while reset is applied and for the
//   first cycle after it, so a new cell may be started in every cycle after.
//   result channel: the fluxes of a cell appear on o_flux for exactly one
//   cycle, marked by o_done, once the cell has passed every pipeline stage.
//   results leave in the order the cells came in. the receiver cannot hold them off,
//   and the pipeline never stalls, so one cell per cycle is sustained.
//   configuration: the enthalpy factor (gamma over gamma minus one, q8.16) is
//   written through i_cfg_valid / o_cfg_ready / i_cfg_data; write it only
//   while no cell is in flight. o_cfg_ready is low during reset and for the
//   first cycle after it.
//   reset: synchronous, active low. it empties the pipeline (in-flight cells
//   are dropped) and sets the enthalpy factor back to 3.5.
//   throughput is set by the longest stage: no multiply in a stage is wider than 33x32,
//   and the other stages hold wide adds, some with saturation or clamping.
module euler_cell_flux_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // cell input channel
    input  logic              start,
    output logic              busy,
    input  ecf_pkg::t_cell_in i_cell,
    // flux result channel
    output logic              o_done,
    output ecf_pkg::t_cell_flux o_flux,
    // enthalpy factor write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ecf_pkg::ENTH_W-1:0] i_cfg_data
);

    // the six unique momentum terms as (row, column) pairs:
    // xx, xy, xz, yy, yz, zz
    localparam int N_MOM = 6;
    localparam int ROW [N_MOM] = '{0, 0, 0, 1, 1, 2};
    localparam int COL [N_MOM] = '{0, 1, 2, 1, 2, 2};
    // pressure goes onto the diagonal terms xx, yy, zz
    localparam logic [N_MOM-1:0] DIAG = 6'b101001;

    // control state
    logic                          r_busy;
    logic [ecf_pkg::ENTH_W-1:0]    r_enth;
    logic [ecf_pkg::PIPE_DEPTH-1:0] r_vld;
    logic                          accept;

    // stage 1: raw density-velocity products and pressure-enthalpy product
    logic signed [31:0] u_in     [3];
    logic signed [63:0] n_s1_mraw [3];
    logic        [55:0] n_s1_praw;
    logic signed [63:0] r_s1_mraw [3];
    logic        [55:0] r_s1_praw;
    logic signed [31:0] r_s1_u   [3];
    logic        [31:0] r_s1_p;

    // stage 2: mass fluxes and split partial products for m_i * u_j
    logic signed [56:0] n_s2_pplo [N_MOM];
    logic signed [55:0] n_s2_pphi [N_MOM];
    logic signed [56:0] r_s2_pplo [N_MOM];
    logic signed [55:0] r_s2_pphi [N_MOM];
    logic signed [47:0] r_s2_m   [3];
    logic signed [31:0] r_s2_u   [3];
    logic        [31:0] r_s2_p;
    logic        [39:0] r_s2_ph;

    // stage 3: momentum terms without pressure
    logic signed [63:0] n_s3_r   [N_MOM];
    logic signed [63:0] r_s3_r   [N_MOM];
    logic signed [47:0] r_s3_m   [3];
    logic signed [31:0] r_s3_u   [3];
    logic        [31:0] r_s3_p;
    logic        [39:0] r_s3_ph;
    logic               diag_neg;

    // stage 4: pressure on the diagonal, doubled kinetic energy sum
    logic signed [63:0] n_s4_mom [N_MOM];
    logic        [63:0] n_s4_kesum;
    logic signed [63:0] r_s4_mom [N_MOM];
    logic        [63:0] r_s4_kesum;
    logic signed [47:0] r_s4_m   [3];
    logic signed [31:0] r_s4_u   [3];
    logic        [39:0] r_s4_ph;

    // stage 5: total enthalpy density
    logic        [61:0] ke;
    logic        [62:0] n_s5_h;
    logic        [62:0] r_s5_h;
    logic signed [63:0] r_s5_mom [N_MOM];
    logic signed [47:0] r_s5_m   [3];
    logic signed [31:0] r_s5_u   [3];

    // stage 6: split partial products for u_i * h
    logic signed [64:0] n_s6_pplo [3];
    logic signed [63:0] n_s6_pphi [3];
    logic signed [64:0] r_s6_pplo [3];
    logic signed [63:0] r_s6_pphi [3];
    logic signed [63:0] r_s6_mom [N_MOM];
    logic signed [47:0] r_s6_m   [3];

    // stage 7: saturated energy fluxes, output word
    logic signed [63:0]  efl [3];
    ecf_pkg::t_cell_flux n_out;
    ecf_pkg::t_cell_flux r_out;

    assign accept      = start && !busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign o_done      = r_vld[ecf_pkg::PIPE_DEPTH-1];
    assign o_flux      = r_out;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_enth <= ecf_pkg::ENTH_RESET;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_enth <= i_cfg_data;
            end
            // valid bits run alongside the data, no stalls
            r_vld <= {r_vld[ecf_pkg::PIPE_DEPTH-2:0], accept};
        end
    end

    // stage 1 logic
    always_comb begin
        logic signed [32:0] rho_s;
        logic signed [64:0] prod;
        rho_s   = $signed({1'b0, i_cell.density});
        u_in[0] = i_cell.velocity_x;
        u_in[1] = i_cell.velocity_y;
        u_in[2] = i_cell.velocity_z;
        for (int i = 0; i < 3; i++) begin
            prod         = rho_s * u_in[i];
            // rho * u always fits 64 bits
            n_s1_mraw[i] = prod[63:0];
        end
        n_s1_praw = 56'(i_cell.pressure) * 56'(r_enth);
    end

    // stage 2 logic: m = floor(raw / 2^16), split into low 24 unsigned bits
    // and high 24 signed bits to keep the multipliers narrow
    always_comb begin
        logic signed [47:0] m;
        logic        [23:0] m_lo;
        logic signed [23:0] m_hi;
        for (int k = 0; k < N_MOM; k++) begin
            m            = $signed(r_s1_mraw[ROW[k]][63:16]);
            m_lo         = m[23:0];
            m_hi         = $signed(m[47:24]);
            n_s2_pplo[k] = $signed({1'b0, m_lo}) * r_s1_u[COL[k]];
            n_s2_pphi[k] = m_hi * r_s1_u[COL[k]];
        end
    end

    // stage 3 logic: recombine and floor; |m * u| / 2^16 stays below 2^62
    always_comb begin
        logic signed [79:0] full;
        for (int k = 0; k < N_MOM; k++) begin
            full      = (80'(r_s2_pphi[k]) <<< 24) + 80'(r_s2_pplo[k]);
            n_s3_r[k] = $signed(full[79:16]);
        end
    end

    assign diag_neg = r_s3_r[0][63] || r_s3_r[3][63] || r_s3_r[5][63];

    // stage 4 logic: diagonal terms are never negative, so no saturation is
    // needed on adding pressure; the kinetic sum may pass 2^63
    always_comb begin
        for (int k = 0; k < N_MOM; k++) begin
            if (DIAG[k]) begin
                n_s4_mom[k] = r_s3_r[k] + $signed({32'b0, r_s3_p});
            end else begin
                n_s4_mom[k] = r_s3_r[k];
            end
        end
        n_s4_kesum = 64'(r_s3_r[0][62:0]) + 64'(r_s3_r[3][62:0])
                   + 64'(r_s3_r[5][62:0]);
    end

    // stage 5 logic: saturate, halve, add pressure work
    always_comb begin
        ke     = r_s4_kesum[63] ? {62{1'b1}} : r_s4_kesum[62:1];
        n_s5_h = 63'(ke) + 63'(r_s4_ph);
    end

    // stage 6 logic: h split into a 32-bit low and a 31-bit high half
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s6_pplo[i] = r_s5_u[i] * $signed({1'b0, r_s5_h[31:0]});
            n_s6_pphi[i] = r_s5_u[i] * $signed({1'b0, r_s5_h[62:32]});
        end
    end

    // stage 7 logic: recombine, floor and clamp to the signed 64-bit range
    always_comb begin
        logic signed [95:0] full;
        logic        [79:0] q;
        for (int i = 0; i < 3; i++) begin
            full = (96'(r_s6_pphi[i]) <<< 32) + 96'(r_s6_pplo[i]);
            q    = full[95:16];
            if ((&q[79:63]) || !(|q[79:63])) begin
                efl[i] = $signed(q[63:0]);
            end else if (q[79]) begin
                efl[i] = {1'b1, {63{1'b0}}};
            end else begin
                efl[i] = {1'b0, {63{1'b1}}};
            end
        end
        n_out.mass_flux_x   = 64'(r_s6_m[0]);
        n_out.mass_flux_y   = 64'(r_s6_m[1]);
        n_out.mass_flux_z   = 64'(r_s6_m[2]);
        n_out.momentum_xx   = r_s6_mom[0];
        n_out.momentum_xy   = r_s6_mom[1];
        n_out.momentum_xz   = r_s6_mom[2];
        n_out.momentum_yy   = r_s6_mom[3];
        n_out.momentum_yz   = r_s6_mom[4];
        n_out.momentum_zz   = r_s6_mom[5];
        n_out.energy_flux_x = efl[0];
        n_out.energy_flux_y = efl[1];
        n_out.energy_flux_z = efl[2];
    end

    // datapath registers, no reset
    always_ff @(posedge i_clk) begin
        r_s1_mraw <= n_s1_mraw;
        r_s1_praw <= n_s1_praw;
        r_s1_u    <= u_in;
        r_s1_p    <= i_cell.pressure;

        r_s2_pplo <= n_s2_pplo;
        r_s2_pphi <= n_s2_pphi;
        for (int i = 0; i < 3; i++) begin
            r_s2_m[i] <= $signed(r_s1_mraw[i][63:16]);
        end
        r_s2_u    <= r_s1_u;
        r_s2_p    <= r_s1_p;
        r_s2_ph   <= r_s1_praw[55:16];

        r_s3_r    <= n_s3_r;
        r_s3_m    <= r_s2_m;
        r_s3_u    <= r_s2_u;
        r_s3_p    <= r_s2_p;
        r_s3_ph   <= r_s2_ph;

        r_s4_mom   <= n_s4_mom;
        r_s4_kesum <= n_s4_kesum;
        r_s4_m     <= r_s3_m;
        r_s4_u     <= r_s3_u;
        r_s4_ph    <= r_s3_ph;

        r_s5_h    <= n_s5_h;
        r_s5_mom  <= r_s4_mom;
        r_s5_m    <= r_s4_m;
        r_s5_u    <= r_s4_u;

        r_s6_pplo <= n_s6_pplo;
        r_s6_pphi <= n_s6_pphi;
        r_s6_mom  <= r_s5_mom;
        r_s6_m    <= r_s5_m;

        r_out     <= n_out;
    end

    // every accepted cell comes out after the full pipeline depth
    `ASSERT_CLK_RST(a_latency, i_clk, i_rst_n, accept |-> ##7 o_done, "accepted cell lost")

    // no result strobe without a matching accept
    `ASSERT_CLK(a_no_phantom, i_clk, o_done |-> $past(accept, 7), "result without cell")

    // diagonal momentum terms without pressure are never negative
    `ASSERT_CLK_RST(a_diag_sign, i_clk, i_rst_n, r_vld[2] |-> !diag_neg, "negative diagonal term")

endmodule

@@ sim/euler_cell_flux_unit_test.sv @@
// self-checking bench for euler_cell_flux_unit: cells in, flux words checked in order
// depends on ecf_pkg and the rtl of euler_cell_flux_unit; reads no files
`timescale 1ns / 1ps

module euler_cell_flux_unit_test;

    localparam int MAX_GAP       = 16;
    localparam int STALL_LIMIT   = 1000;
    localparam int CELLS_PER_CFG = 30;
    localparam int RANDOM_BLOCKS = 8;
    localparam int BLOCK_CELLS   = 100;

    localparam logic signed [127:0] WIDE_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] WIDE_MIN = -128'sh8000_0000_0000_0000;
    localparam logic signed [63:0]  SAT_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0]  SAT_MIN  = 64'sh8000_0000_0000_0000;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        start       = 1'b0;
    logic                        busy;
    ecf_pkg::t_cell_in           i_cell      = '0;
    logic                        o_done;
    ecf_pkg::t_cell_flux         o_flux;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [ecf_pkg::ENTH_W-1:0]  i_cfg_data  = '0;

    // bench state shared by the stimulus and the checker
    ecf_pkg::t_cell_flux         flux_due_q[$];
    logic [ecf_pkg::ENTH_W-1:0]  enth_model  = ecf_pkg::ENTH_RESET;
    bit                          idle_on     = 1'b0;
    int                          error_count = 0;
    int                          cells_sent  = 0;
    int                          flux_checked = 0;
    int                          cfg_writes  = 0;
    int                          stall_cycles = 0;

    euler_cell_flux_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cell      (i_cell),
        .o_done      (o_done),
        .o_flux      (o_flux),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // flux predictor
    // ------------------------------------------------------------------

    // q16 product, floored (toward minus infinity) then clamped to 64 bits
    function automatic logic signed [63:0] q16_mul(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [127:0] wa;
        logic signed [127:0] wb;
        logic signed [127:0] prod;
        wa   = a;
        wb   = b;
        prod = (wa * wb) >>> 16;
        if (prod > WIDE_MAX) return SAT_MAX;
        if (prod < WIDE_MIN) return SAT_MIN;
        return prod[63:0];
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? SAT_MIN : SAT_MAX;
        return s[63:0];
    endfunction

    function automatic ecf_pkg::t_cell_flux cell_flux_of(
        input ecf_pkg::t_cell_in c,
        input logic [ecf_pkg::ENTH_W-1:0] enth);
        ecf_pkg::t_cell_flux f;
        logic signed [63:0]  rho;
        logic signed [63:0]  pres;
        logic signed [63:0]  vel[3];
        logic signed [63:0]  mass[3];
        logic signed [63:0]  rr[3][3];
        logic signed [63:0]  kin;
        logic signed [63:0]  enthalpy;
        rho    = {32'b0, c.density};
        pres   = {32'b0, c.pressure};
        vel[0] = $signed(c.velocity_x);
        vel[1] = $signed(c.velocity_y);
        vel[2] = $signed(c.velocity_z);
        for (int i = 0; i < 3; i++) mass[i] = q16_mul(rho, vel[i]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) rr[i][j] = q16_mul(mass[i], vel[j]);
        // kinetic energy: half the saturated trace, without pressure
        kin      = sat_add(sat_add(rr[0][0], rr[1][1]), rr[2][2]);
        kin      = {1'b0, kin[63:1]};
        enthalpy = sat_add(kin, q16_mul(pres, {40'b0, enth}));
        f.mass_flux_x   = mass[0];
        f.mass_flux_y   = mass[1];
        f.mass_flux_z   = mass[2];
        f.momentum_xx   = sat_add(rr[0][0], pres);
        f.momentum_xy   = rr[0][1];
        f.momentum_xz   = rr[0][2];
        f.momentum_yy   = sat_add(rr[1][1], pres);
        f.momentum_yz   = rr[1][2];
        f.momentum_zz   = sat_add(rr[2][2], pres);
        f.energy_flux_x = q16_mul(vel[0], enthalpy);
        f.energy_flux_y = q16_mul(vel[1], enthalpy);
        f.energy_flux_z = q16_mul(vel[2], enthalpy);
        return f;
    endfunction

    // ------------------------------------------------------------------
    // checker: follows every handshake at the rising edge
    // ------------------------------------------------------------------

    task automatic check_word(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (got !== want) begin
            $error("%s expected %h actual %h", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_flux(input ecf_pkg::t_cell_flux want,
                              input ecf_pkg::t_cell_flux got);
        check_word("mass_flux_x",   want.mass_flux_x,   got.mass_flux_x);
        check_word("mass_flux_y",   want.mass_flux_y,   got.mass_flux_y);
        check_word("mass_flux_z",   want.mass_flux_z,   got.mass_flux_z);
        check_word("momentum_xx",   want.momentum_xx,   got.momentum_xx);
        check_word("momentum_xy",   want.momentum_xy,   got.momentum_xy);
        check_word("momentum_xz",   want.momentum_xz,   got.momentum_xz);
        check_word("momentum_yy",   want.momentum_yy,   got.momentum_yy);
        check_word("momentum_yz",   want.momentum_yz,   got.momentum_yz);
        check_word("momentum_zz",   want.momentum_zz,   got.momentum_zz);
        check_word("energy_flux_x", want.energy_flux_x, got.energy_flux_x);
        check_word("energy_flux_y", want.energy_flux_y, got.energy_flux_y);
        check_word("energy_flux_z", want.energy_flux_z, got.energy_flux_z);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            enth_model = ecf_pkg::ENTH_RESET;
        end else begin
            // register write only ever happens with the pipeline empty
            if (i_cfg_valid && o_cfg_ready) begin
                enth_model = i_cfg_data;
                cfg_writes++;
            end
            // check before queueing so a result in the same cycle as its cell cannot pass
            if (o_done) begin
                if (flux_due_q.size() == 0) begin
                    $error("flux word with no cell outstanding");
                    error_count++;
                end else begin
                    check_flux(flux_due_q.pop_front(), o_flux);
                    flux_checked++;
                end
            end
            if (start && !busy) begin
                flux_due_q = {flux_due_q, cell_flux_of(i_cell, enth_model)};
                cells_sent++;
            end
        end
    end

    // watchdog: cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offer one cell, with an optional idle gap first, and wait until taken
    task automatic send_cell(input ecf_pkg::t_cell_in c);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_cell <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // stop offering cells and wait until every flux word has come back
    task automatic drain_cells();
        start <= 1'b0;
        do @(posedge i_clk); while (flux_due_q.size() != 0);
    endtask

    task automatic write_enthalpy(input logic [ecf_pkg::ENTH_W-1:0] value);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        repeat (gap) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic ecf_pkg::t_cell_in make_cell(
        input logic [31:0] d, input logic [31:0] vx,
        input logic [31:0] vy, input logic [31:0] vz,
        input logic [31:0] p);
        ecf_pkg::t_cell_in c;
        c.density    = d;
        c.velocity_x = vx;
        c.velocity_y = vy;
        c.velocity_z = vz;
        c.pressure   = p;
        return c;
    endfunction

    // mix of full-range, small, mid-range and corner values
    function automatic logic [31:0] rand_field(input bit is_signed);
        logic [31:0] w;
        case ($urandom_range(0, 3))
            0: w = $urandom;
            1: w = $urandom_range(0, 32'h0004_0000);
            2: w = $urandom & 32'h00FF_FFFF;
            default: begin
                case ($urandom_range(0, 4))
                    0: w = 32'h0000_0000;
                    1: w = 32'h0000_0001;
                    2: w = 32'h7FFF_FFFF;
                    3: w = 32'h8000_0000;
                    default: w = 32'hFFFF_FFFF;
                endcase
            end
        endcase
        if (is_signed && $urandom_range(0, 1) && w[31] == 1'b0) w = -w;
        return w;
    endfunction

    function automatic ecf_pkg::t_cell_in rand_cell();
        return make_cell(rand_field(1'b0), rand_field(1'b1), rand_field(1'b1),
                         rand_field(1'b1), rand_field(1'b0));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        idle_on = 1'b0;
        // all zero, then plain unit values with mixed signs
        send_cell(make_cell(32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
        send_cell(make_cell(32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
                            32'hFFFD_0000, 32'h0001_0000));
        // largest magnitudes: saturation of the trace and the energy terms
        send_cell(make_cell(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_cell(make_cell(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'hFFFF_FFFF));
        send_cell(make_cell(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h0, 32'h0));
        // tiny negative products must floor, not truncate toward zero
        send_cell(make_cell(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'h0));
        send_cell(make_cell(32'h0001_0000, 32'hFFFF_8000, 32'h0000_8000,
                            32'hFFFF_FFFF, 32'h0));
        send_cell(make_cell(32'h0000_0003, 32'hFFFF_AAAB, 32'h0000_5555,
                            32'hFFFF_0001, 32'h0000_0001));
        // no mass, only pressure on the diagonal and in the enthalpy
        send_cell(make_cell(32'h0, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h0001_0000, 32'hFFFF_FFFF));
        send_cell(make_cell(32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000,
                            32'h1234_5678, 32'h0001_8000));
        send_cell(make_cell(32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                            32'h8000_0001, 32'h8000_0000));
        send_cell(make_cell(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'hCCCC_CCCC, 32'h3333_3333));
        send_cell(make_cell(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'h3333_3333, 32'hCCCC_CCCC));
        // momentum near the top without clamping, energy forced to clamp
        send_cell(make_cell(32'hFFFF_FFFF, 32'h4000_0000, 32'hC000_0000,
                            32'h0, 32'h0000_0001));
    endtask

    // enthalpy factor at its extremes and in between, each phase with idle pipe
    task automatic test_enthalpy_factor();
        logic [ecf_pkg::ENTH_W-1:0] factors[5];
        factors[0] = '0;
        factors[1] = '1;
        factors[2] = 24'd1;
        factors[3] = 24'($urandom);
        factors[4] = ecf_pkg::ENTH_RESET;
        for (int s = 0; s < 5; s++) begin
            drain_cells();
            idle_on = s[0];
            write_enthalpy(factors[s]);
            for (int n = 0; n < CELLS_PER_CFG; n++) send_cell(rand_cell());
        end
    endtask

    // bulk random traffic, idling and back-to-back blocks alternating
    task automatic test_random_stream();
        bit first;
        first = ($urandom_range(0, 1) != 0);
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            idle_on = first ^ blk[0];
            for (int n = 0; n < BLOCK_CELLS; n++) send_cell(rand_cell());
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_enthalpy_factor();
        test_random_stream();

        drain_cells();
        // let any stray word surface before the verdict
        repeat (ecf_pkg::PIPE_DEPTH + 4) @(posedge i_clk);

        $display("%0d cells sent, %0d flux words checked, %0d enthalpy factor writes",
                 cells_sent, flux_checked, cfg_writes);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", error_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/ecf_pkg.sv
design/euler_cell_flux_unit.sv
sim/euler_cell_flux_unit_test.sv
